// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/lfu_pkg.sv
package lfu_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int ID_WIDTH_DEF = 16;
    localparam int COUNT_W      = 16;
    localparam int AGE_W        = 32;
    localparam int IN_ID_W      = 16;
    localparam int OUT_SLOT_W   = 5;
    localparam int FIU_W        = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [FIU_W-1:0]   FIU_RESET = FIU_W'(32);

    typedef struct packed {
        logic match;
        logic better;
    } lfu_cmp_t;

endpackage

// File: hdl/lfu_ram.sv
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/lfu_cmp.sv
module lfu_cmp #(
    parameter int ID_WIDTH = lfu_pkg::ID_WIDTH_DEF
) (
    input  logic [ID_WIDTH-1:0]       key_id,
    input  logic [ID_WIDTH-1:0]       ent_id,
    input  logic [lfu_pkg::COUNT_W-1:0] ent_count,
    input  logic [lfu_pkg::AGE_W-1:0]   ent_age,
    input  logic [lfu_pkg::COUNT_W-1:0] best_count,
    input  logic [lfu_pkg::AGE_W-1:0]   best_age,
    input  logic                      first,
    output lfu_pkg::lfu_cmp_t         result
);

    import lfu_pkg::*;

    always_comb begin
        result.match  = (key_id == ent_id);
        result.better = first || (ent_count < best_count) ||
                        ((ent_count == best_count) && (ent_age < best_age));
    end

endmodule

// File: hdl/lfu_slot_table_with_age_tiebreak.sv
// Flow: an accepted item goes straight to the finish state when the table is empty; otherwise
// the scan reads one slot per cycle through the slot memory's read port and stops at a hit
// or at the last filled slot. No new item is accepted until the current one leaves the
// finish state, which waits while an earlier result is still held for m_ready.
// Reset: control state clears, frames_in_use returns to 32, the slot memory is not
// cleared; only filled slots are ever compared.
module lfu_slot_table_with_age_tiebreak #(
    parameter int SLOTS    = lfu_pkg::SLOTS_DEF,
    parameter int ID_WIDTH = lfu_pkg::ID_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::FIU_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lfu_pkg::IN_ID_W-1:0]    s_candidate_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lfu_pkg::OUT_SLOT_W-1:0] m_slot_index,
    output logic                          m_was_hit,
    output logic                          m_did_evict,
    output logic [lfu_pkg::IN_ID_W-1:0]    m_evicted_id,
    output logic [lfu_pkg::COUNT_W-1:0]    m_new_count
);

    import lfu_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(SLOTS + 1);
    localparam int ENT_W = ID_WIDTH + COUNT_W + AGE_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t               state_reg;
    logic [FIU_W-1:0]     fiu_reg;
    logic [FW-1:0]        fill_reg;
    logic [AGE_W-1:0]     arrival_reg;
    logic [SW-1:0]        cmp_idx_reg;
    logic [SW-1:0]        best_idx_reg;
    logic [ID_WIDTH-1:0]  id_reg;
    logic [AGE_W-1:0]     now_reg;
    logic [ID_WIDTH-1:0]  best_id_reg;
    logic [COUNT_W-1:0]   best_count_reg;
    logic [AGE_W-1:0]     best_age_reg;
    logic                 hit_reg;
    logic                 m_valid_reg;
    logic [OUT_SLOT_W-1:0] m_slot_reg;
    logic                 m_hit_reg;
    logic                 m_evict_reg;
    logic [IN_ID_W-1:0]   m_evicted_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    logic                 accept;
    logic                 proceed;
    logic                 full;
    logic                 last;
    logic [31:0]          cand_ext;
    logic [ID_WIDTH-1:0]  cand_id;
    logic [31:0]          fiu_ext;
    logic [31:0]          lim_ext;
    logic [FW-1:0]        limit;
    logic [SW-1:0]        rd_addr;
    logic [ENT_W-1:0]     rd_data;
    logic [ID_WIDTH-1:0]  rd_id;
    logic [COUNT_W-1:0]   rd_count;
    logic [AGE_W-1:0]     rd_age;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic [COUNT_W-1:0]   inc_count;
    logic [31:0]          fill_ext;
    logic [31:0]          slot_ext;
    logic [31:0]          evict_ext;
    lfu_cmp_t             cmp_res;

    assign cand_ext = 32'(s_candidate_id);
    assign cand_id  = cand_ext[ID_WIDTH-1:0];
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign proceed  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign fill_ext = 32'(fill_reg);
    assign last     = ((32'(cmp_idx_reg) + 32'd1) == fill_ext);

    always_comb begin
        fiu_ext = 32'(fiu_reg);
        if (fiu_ext == 32'd0) begin
            lim_ext = 32'd1;
        end else if (fiu_ext > 32'(SLOTS)) begin
            lim_ext = 32'(SLOTS);
        end else begin
            lim_ext = fiu_ext;
        end
        limit = FW'(lim_ext);
    end

    assign full = (fill_reg >= limit);

    assign rd_addr  = (state_reg == ST_IDLE) ? '0 : SW'(32'(cmp_idx_reg) + 32'd1);
    assign rd_age   = rd_data[AGE_W-1:0];
    assign rd_count = rd_data[AGE_W +: COUNT_W];
    assign rd_id    = rd_data[AGE_W+COUNT_W +: ID_WIDTH];

    lfu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfu_cmp #(
        .ID_WIDTH (ID_WIDTH)
    ) u_cmp (
        .key_id     (id_reg),
        .ent_id     (rd_id),
        .ent_count  (rd_count),
        .ent_age    (rd_age),
        .best_count (best_count_reg),
        .best_age   (best_age_reg),
        .first      (cmp_idx_reg == '0),
        .result     (cmp_res)
    );

    assign inc_count = (best_count_reg == COUNT_MAX) ? best_count_reg
                                                     : best_count_reg + COUNT_W'(1);

    always_comb begin
        wr_en = proceed;
        if (hit_reg) begin
            wr_addr = best_idx_reg;
            wr_data = {best_id_reg, inc_count, best_age_reg};
        end else if (!full) begin
            wr_addr = fill_ext[SW-1:0];
            wr_data = {id_reg, COUNT_W'(1), now_reg};
        end else begin
            wr_addr = best_idx_reg;
            wr_data = {id_reg, COUNT_W'(1), now_reg};
        end
    end

    assign slot_ext  = 32'(wr_addr);
    assign evict_ext = 32'(best_id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fiu_reg     <= FIU_RESET;
            fill_reg    <= '0;
            arrival_reg <= '0;
            cmp_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fiu_reg <= cfg_wr_data;
            end
            if (proceed) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmp_idx_reg <= '0;
                        state_reg   <= (fill_reg == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cmp_res.match || last) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        cmp_idx_reg <= cmp_idx_reg + SW'(1);
                    end
                end
                ST_FINISH: begin
                    if (proceed) begin
                        state_reg <= ST_IDLE;
                        if (!hit_reg && !full) begin
                            fill_reg <= fill_reg + FW'(1);
                        end
                        if (arrival_reg != AGE_MAX) begin
                            arrival_reg <= arrival_reg + AGE_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg  <= cand_id;
            now_reg <= arrival_reg;
            hit_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN) begin
            if (cmp_res.match) begin
                hit_reg <= 1'b1;
            end
            if (cmp_res.match || cmp_res.better) begin
                best_idx_reg   <= cmp_idx_reg;
                best_id_reg    <= rd_id;
                best_count_reg <= rd_count;
                best_age_reg   <= rd_age;
            end
        end
        if (proceed) begin
            m_slot_reg    <= slot_ext[OUT_SLOT_W-1:0];
            m_hit_reg     <= hit_reg;
            m_evict_reg   <= !hit_reg && full;
            m_evicted_reg <= (!hit_reg && full) ? evict_ext[IN_ID_W-1:0] : '0;
            m_count_reg   <= hit_reg ? inc_count : COUNT_W'(1);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_reg;
    assign m_was_hit    = m_hit_reg;
    assign m_did_evict  = m_evict_reg;
    assign m_evicted_id = m_evicted_reg;
    assign m_new_count  = m_count_reg;

endmodule

// File: hdl/lfu_checker.sv
`include "assert_macros.svh"

module lfu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [lfu_pkg::OUT_SLOT_W-1:0] m_slot_index,
    input logic                          m_was_hit,
    input logic                          m_did_evict,
    input logic [lfu_pkg::IN_ID_W-1:0]    m_evicted_id,
    input logic [lfu_pkg::COUNT_W-1:0]    m_new_count
);

    import lfu_pkg::*;

    `ASSERT_RST(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_slot_index) && $stable(m_new_count), "result changed while stalled")
    `ASSERT_RST(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready stayed high after an item was accepted")
    `ASSERT_RST(a_hit_no_evict, m_valid && m_was_hit |-> !m_did_evict && (m_evicted_id == '0), "hit reported an eviction")
    `ASSERT_RST(a_miss_count_one, m_valid && !m_was_hit |-> (m_new_count == COUNT_W'(1)), "new entry count is not one")

endmodule

bind lfu_slot_table_with_age_tiebreak lfu_checker u_lfu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_slot_index (m_slot_index),
    .m_was_hit    (m_was_hit),
    .m_did_evict  (m_did_evict),
    .m_evicted_id (m_evicted_id),
    .m_new_count  (m_new_count)
);

// File: verif/lfu_slot_table_with_age_tiebreak_tb.sv
module lfu_slot_table_with_age_tiebreak_tb;

    localparam int SLOTS             = lfu_pkg::SLOTS_DEF;
    localparam int ID_W              = lfu_pkg::IN_ID_W;
    localparam int LIMIT_CYCLES      = 2_000_000;
    localparam int TAIL_CYCLES       = 40;
    localparam int HOLD_CYCLES       = 300;
    localparam int ITEMS_PER_PHASE   = 170;
    localparam int HOLD_PHASE_ITEMS  = 80;
    localparam int NUM_PHASES        = 8;
    localparam int NUM_ROWS          = 21;

    typedef enum logic {
        ROW_ITEM,
        ROW_FRAMES
    } row_kind_t;

    typedef struct packed {
        logic [lfu_pkg::OUT_SLOT_W-1:0] slot_index;
        logic                           was_hit;
        logic                           did_evict;
        logic [lfu_pkg::IN_ID_W-1:0]    evicted_id;
        logic [lfu_pkg::COUNT_W-1:0]    new_count;
    } table_result_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [ID_W-1:0] value;
        logic          fixed;
        table_result_t result;
    } directed_row_t;

    logic                           aclk;
    logic                           aresetn        = 1'b0;
    logic                           cfg_wr_en      = 1'b0;
    logic [lfu_pkg::FIU_W-1:0]      cfg_wr_data    = '0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic [ID_W-1:0]                s_candidate_id = '0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [lfu_pkg::OUT_SLOT_W-1:0] m_slot_index;
    logic                           m_was_hit;
    logic                           m_did_evict;
    logic [ID_W-1:0]                m_evicted_id;
    logic [lfu_pkg::COUNT_W-1:0]    m_new_count;

    logic                           hold_req       = 1'b0;
    int                             sender_idle_pct    = 0;
    int                             receiver_stall_pct = 0;
    int                             cycle_count    = 0;
    int                             failures       = 0;
    int                             items_sent     = 0;
    int                             results_seen   = 0;
    int                             hits_seen      = 0;
    int                             evictions_seen = 0;
    int                             frame_writes   = 0;

    logic [ID_W-1:0]                table_ids    [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0]    table_counts [SLOTS];
    logic [lfu_pkg::AGE_W-1:0]      table_ages   [SLOTS];
    int unsigned                    table_filled  = 0;
    logic [lfu_pkg::AGE_W-1:0]      arrival_num   = '0;
    logic [lfu_pkg::FIU_W-1:0]      frames_limit  = lfu_pkg::FIU_RESET;

    table_result_t                  pending_results [$];

    directed_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ITEM,   16'h0000, 1'b1, '{5'd0, 1'b0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_ITEM,   16'hFFFF, 1'b1, '{5'd1, 1'b0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_ITEM,   16'h0000, 1'b1, '{5'd0, 1'b1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_ITEM,   16'hFFFF, 1'b1, '{5'd1, 1'b1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_ITEM,   16'hAAAA, 1'b1, '{5'd2, 1'b0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_ITEM,   16'h5555, 1'b1, '{5'd3, 1'b0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_FRAMES, 16'd4,    1'b0, '0},
        '{ROW_ITEM,   16'h1234, 1'b1, '{5'd2, 1'b0, 1'b1, 16'hAAAA, 16'd1}},
        '{ROW_ITEM,   16'h4321, 1'b1, '{5'd3, 1'b0, 1'b1, 16'h5555, 16'd1}},
        '{ROW_FRAMES, 16'd0,    1'b0, '0},
        '{ROW_ITEM,   16'h0001, 1'b1, '{5'd2, 1'b0, 1'b1, 16'h1234, 16'd1}},
        '{ROW_FRAMES, 16'd63,   1'b0, '0},
        '{ROW_ITEM,   16'h8000, 1'b1, '{5'd4, 1'b0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_ITEM,   16'h0001, 1'b1, '{5'd2, 1'b1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_ITEM,   16'h0000, 1'b1, '{5'd0, 1'b1, 1'b0, 16'h0000, 16'd3}},
        '{ROW_FRAMES, 16'd1,    1'b0, '0},
        '{ROW_ITEM,   16'h7FFF, 1'b1, '{5'd3, 1'b0, 1'b1, 16'h4321, 16'd1}},
        '{ROW_ITEM,   16'h7FFF, 1'b1, '{5'd3, 1'b1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_FRAMES, 16'd32,   1'b0, '0},
        '{ROW_ITEM,   16'h00FF, 1'b0, '0},
        '{ROW_ITEM,   16'hFF00, 1'b0, '0}
    };

    logic [lfu_pkg::FIU_W-1:0] phase_frames   [NUM_PHASES] =
        '{6'd8, 6'd3, 6'd0, 6'd32, 6'd63, 6'd1, 6'd17, 6'd33};
    int                        phase_sender   [4]          = '{0, 45, 0, 20};
    int                        phase_receiver [4]          = '{0, 0, 45, 20};

    lfu_slot_table_with_age_tiebreak i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_candidate_id (s_candidate_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_index   (m_slot_index),
        .m_was_hit      (m_was_hit),
        .m_did_evict    (m_did_evict),
        .m_evicted_id   (m_evicted_id),
        .m_new_count    (m_new_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic table_result_t apply_hit(input logic [ID_W-1:0] id);
        table_result_t r;
        int unsigned   limit;
        int unsigned   slot;
        int unsigned   best;
        r     = '0;
        slot  = 0;
        limit = (frames_limit == 0) ? 1 : (frames_limit > SLOTS) ? SLOTS : frames_limit;
        for (int j = 0; j < table_filled; j++) begin
            if (table_ids[j] == id) begin
                r.was_hit = 1'b1;
                slot = j;
                break;
            end
        end
        if (r.was_hit) begin
            if (table_counts[slot] != lfu_pkg::COUNT_MAX) begin
                table_counts[slot]++;
            end
            hits_seen++;
        end else begin
            if (table_filled < limit) begin
                slot = table_filled;
                table_filled++;
            end else begin
                best = 0;
                for (int j = 1; j < table_filled; j++) begin
                    if (table_counts[j] < table_counts[best] ||
                        (table_counts[j] == table_counts[best] &&
                         table_ages[j] < table_ages[best])) begin
                        best = j;
                    end
                end
                slot         = best;
                r.did_evict  = 1'b1;
                r.evicted_id = table_ids[slot];
                evictions_seen++;
            end
            table_ids[slot]    = id;
            table_counts[slot] = lfu_pkg::COUNT_W'(1);
            table_ages[slot]   = arrival_num;
        end
        r.slot_index = slot[lfu_pkg::OUT_SLOT_W-1:0];
        r.new_count  = table_counts[slot];
        if (arrival_num != lfu_pkg::AGE_MAX) begin
            arrival_num++;
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] previous);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return ID_W'($urandom_range(0, 47));
        end
        if (roll < 70) begin
            return previous;
        end
        return ID_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            failures++;
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        end
    endfunction

    task automatic offer_id(input logic [ID_W-1:0] id, input logic fixed,
                            input table_result_t typed_result);
        table_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_candidate_id <= id;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = apply_hit(id);
        pending_results = {pending_results, (fixed ? typed_result : predicted)};
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_frames(input logic [lfu_pkg::FIU_W-1:0] value);
        drain();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        frames_limit  = value;
        frame_writes++;
    endtask

    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        table_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                $error("result with no item waiting: slot_index 'h%0h", m_slot_index);
            end else begin
                want = pending_results.pop_front();
                check_field("slot_index", 32'(want.slot_index), 32'(m_slot_index));
                check_field("was_hit", 32'(want.was_hit), 32'(m_was_hit));
                check_field("did_evict", 32'(want.did_evict), 32'(m_did_evict));
                check_field("evicted_id", 32'(want.evicted_id), 32'(m_evicted_id));
                check_field("new_count", 32'(want.new_count), 32'(m_new_count));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [ID_W-1:0] last_id;
        last_id = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_FRAMES) begin
                write_frames(directed_rows[r].value[lfu_pkg::FIU_W-1:0]);
            end else begin
                offer_id(directed_rows[r].value, directed_rows[r].fixed,
                         directed_rows[r].result);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_frames(phase_frames[p]);
            sender_idle_pct    = phase_sender[p % 4];
            receiver_stall_pct = phase_receiver[p % 4];
            repeat (ITEMS_PER_PHASE) begin
                last_id = pick_id(last_id);
                offer_id(last_id, 1'b0, '0);
            end
        end

        write_frames(lfu_pkg::FIU_W'($urandom_range(0, 63)));
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        repeat (HOLD_PHASE_ITEMS) begin
            last_id = pick_id(last_id);
            offer_id(last_id, 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d ids (%0d hits, %0d evictions) across %0d table-size writes,",
                 items_sent, hits_seen, evictions_seen, frame_writes);
        $display("with sender gaps, receiver stalls and one long output stall; %0d checked.",
                 results_seen);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
